// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the accumulator step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/acs_pkg.sv =====
// Types, codes and the microcode program of the accumulator step block.
package acs_pkg;

   // Field widths
   localparam int unsigned ADDR_BITS     = 27;
   localparam int unsigned DATA_BITS     = 32;
   localparam int unsigned OPC_BITS      = 5;
   localparam int unsigned OPC_SHIFT     = 27;
   localparam int unsigned MODE_BITS     = 2;
   localparam int unsigned STATUS_BITS   = 3;
   localparam int unsigned UPC_BITS      = 5;
   localparam int unsigned MEM_WORDS_DEF = 1024;

   typedef logic [MODE_BITS-1:0]   mode_type;
   typedef logic [OPC_BITS-1:0]    opc_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [UPC_BITS-1:0]    upc_type;

   // Request modes
   localparam mode_type MODE_WRITE = 2'd0;
   localparam mode_type MODE_EXEC  = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;
   localparam mode_type MODE_NONE  = 2'd3;

   // Instruction opcodes
   localparam opc_type OP_LDA = 5'h01;
   localparam opc_type OP_STA = 5'h02;
   localparam opc_type OP_LDB = 5'h03;
   localparam opc_type OP_STB = 5'h04;
   localparam opc_type OP_ADD = 5'h05;
   localparam opc_type OP_SUB = 5'h06;
   localparam opc_type OP_JMP = 5'h07;
   localparam opc_type OP_JZ  = 5'h08;
   localparam opc_type OP_HLT = 5'h1F;

   // Result status codes
   localparam status_type ST_ACCESS  = 3'd0;
   localparam status_type ST_EXEC    = 3'd1;
   localparam status_type ST_HALT    = 3'd2;
   localparam status_type ST_BAD_OP  = 3'd3;
   localparam status_type ST_HALTED  = 3'd4;

   // Microcode addresses; the clear loop falls through into idle
   localparam upc_type U_CLEAR  = 5'd0;
   localparam upc_type U_IDLE   = 5'd1;
   localparam upc_type U_WR     = 5'd2;
   localparam upc_type U_RD     = 5'd3;
   localparam upc_type U_RD2    = 5'd4;
   localparam upc_type U_EXEC   = 5'd5;
   localparam upc_type U_FETCH  = 5'd6;
   localparam upc_type U_LDA    = 5'd7;
   localparam upc_type U_LDA2   = 5'd8;
   localparam upc_type U_STA    = 5'd9;
   localparam upc_type U_LDB    = 5'd10;
   localparam upc_type U_LDB2   = 5'd11;
   localparam upc_type U_STB    = 5'd12;
   localparam upc_type U_ADD    = 5'd13;
   localparam upc_type U_SUB    = 5'd14;
   localparam upc_type U_JMP    = 5'd15;
   localparam upc_type U_JZ     = 5'd16;
   localparam upc_type U_HLT    = 5'd17;
   localparam upc_type U_BAD    = 5'd18;
   localparam upc_type U_HALTED = 5'd19;

   // Channel payloads
   typedef struct packed {
      mode_type               mode;
      logic [ADDR_BITS-1:0]   address;
      logic [DATA_BITS-1:0]   data;
   } req_type;

   typedef struct packed {
      status_type             status;
      opc_type                opcode;
      logic [DATA_BITS-1:0]   accumulator;
      logic [DATA_BITS-1:0]   b_value;
      logic [ADDR_BITS-1:0]   pc;
      logic                   zero;
      logic [DATA_BITS-1:0]   read_data;
      logic                   mem_written;
   } rsp_type;

   // Control word fields
   typedef enum logic [1:0] {
      MEM_IDLE = 2'd0,
      MEM_RD   = 2'd1,
      MEM_WR   = 2'd2
   } mem_op_type;

   typedef enum logic [1:0] {
      ADDR_REQ  = 2'd0,
      ADDR_PC   = 2'd1,
      ADDR_OPND = 2'd2,
      ADDR_CLR  = 2'd3
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_REQ  = 2'd0,
      WD_ACC  = 2'd1,
      WD_B    = 2'd2,
      WD_ZERO = 2'd3
   } wd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2,
      ACC_SUB  = 2'd3
   } acc_op_type;

   typedef enum logic [1:0] {
      PC_HOLD = 2'd0,
      PC_INC  = 2'd1,
      PC_LOAD = 2'd2,
      PC_JZ   = 2'd3
   } pc_op_type;

   typedef enum logic [2:0] {
      SEQ_NEXT      = 3'd0,
      SEQ_JUMP      = 3'd1,
      SEQ_CLR_LOOP  = 3'd2,
      SEQ_DISP_MODE = 3'd3,
      SEQ_BR_HALT   = 3'd4,
      SEQ_DISP_OPC  = 3'd5
   } seq_op_type;

   // Datapath half of a control word
   typedef struct packed {
      mem_op_type   mem_op;
      addr_sel_type addr_sel;
      wd_sel_type   wd_sel;
      acc_op_type   acc_op;
      logic         b_load;
      pc_op_type    pc_op;
      logic         ir_load;
      logic         rd_load;
      logic         halt;
      logic         st_set;
      status_type   st_val;
      logic         written;
      logic         clr_step;
   } dp_ctrl_type;

   typedef struct packed {
      dp_ctrl_type dp;
      seq_op_type  seq;
      upc_type     target;
   } uword_type;

   // Handshake events raised by the sequencer
   typedef struct packed {
      logic accept;
      logic emit;
   } evt_type;

   // Datapath conditions seen by the sequencer
   typedef struct packed {
      logic    running;
      logic    clr_last;
      logic    out_free;
      opc_type opcode;
   } flags_type;

   function automatic dp_ctrl_type dp_nop();
      dp_ctrl_type d;
      d.mem_op   = MEM_IDLE;
      d.addr_sel = ADDR_REQ;
      d.wd_sel   = WD_REQ;
      d.acc_op   = ACC_HOLD;
      d.b_load   = 1'b0;
      d.pc_op    = PC_HOLD;
      d.ir_load  = 1'b0;
      d.rd_load  = 1'b0;
      d.halt     = 1'b0;
      d.st_set   = 1'b0;
      d.st_val   = ST_ACCESS;
      d.written  = 1'b0;
      d.clr_step = 1'b0;
      return d;
   endfunction

   // Microcode ROM: one control word per step
   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      w.dp     = dp_nop();
      w.seq    = SEQ_JUMP;
      w.target = U_IDLE;
      case (upc)
         U_CLEAR: begin
            w.dp.mem_op   = MEM_WR;
            w.dp.addr_sel = ADDR_CLR;
            w.dp.wd_sel   = WD_ZERO;
            w.dp.clr_step = 1'b1;
            w.seq         = SEQ_CLR_LOOP;
         end
         U_IDLE: begin
            w.seq = SEQ_DISP_MODE;
         end
         U_WR: begin
            w.dp.mem_op   = MEM_WR;
            w.dp.addr_sel = ADDR_REQ;
            w.dp.wd_sel   = WD_REQ;
         end
         U_RD: begin
            w.dp.mem_op   = MEM_RD;
            w.dp.addr_sel = ADDR_REQ;
            w.seq         = SEQ_NEXT;
         end
         U_RD2: begin
            w.dp.rd_load = 1'b1;
         end
         U_EXEC: begin
            w.dp.mem_op   = MEM_RD;
            w.dp.addr_sel = ADDR_PC;
            w.seq         = SEQ_BR_HALT;
            w.target      = U_HALTED;
         end
         U_FETCH: begin
            w.dp.ir_load = 1'b1;
            w.dp.st_set  = 1'b1;
            w.dp.st_val  = ST_EXEC;
            w.seq        = SEQ_DISP_OPC;
         end
         U_LDA, U_LDB: begin
            w.dp.mem_op   = MEM_RD;
            w.dp.addr_sel = ADDR_OPND;
            w.seq         = SEQ_NEXT;
         end
         U_LDA2: begin
            w.dp.acc_op = ACC_LOAD;
            w.dp.pc_op  = PC_INC;
         end
         U_LDB2: begin
            w.dp.b_load = 1'b1;
            w.dp.pc_op  = PC_INC;
         end
         U_STA: begin
            w.dp.mem_op   = MEM_WR;
            w.dp.addr_sel = ADDR_OPND;
            w.dp.wd_sel   = WD_ACC;
            w.dp.written  = 1'b1;
            w.dp.pc_op    = PC_INC;
         end
         U_STB: begin
            w.dp.mem_op   = MEM_WR;
            w.dp.addr_sel = ADDR_OPND;
            w.dp.wd_sel   = WD_B;
            w.dp.written  = 1'b1;
            w.dp.pc_op    = PC_INC;
         end
         U_ADD: begin
            w.dp.acc_op = ACC_ADD;
            w.dp.pc_op  = PC_INC;
         end
         U_SUB: begin
            w.dp.acc_op = ACC_SUB;
            w.dp.pc_op  = PC_INC;
         end
         U_JMP: begin
            w.dp.pc_op = PC_LOAD;
         end
         U_JZ: begin
            w.dp.pc_op = PC_JZ;
         end
         U_HLT: begin
            w.dp.halt   = 1'b1;
            w.dp.st_set = 1'b1;
            w.dp.st_val = ST_HALT;
         end
         U_BAD: begin
            w.dp.halt   = 1'b1;
            w.dp.st_set = 1'b1;
            w.dp.st_val = ST_BAD_OP;
         end
         U_HALTED: begin
            w.dp.st_set = 1'b1;
            w.dp.st_val = ST_HALTED;
         end
         default: begin
            w.seq = SEQ_JUMP;
         end
      endcase
      return w;
   endfunction

   // Entry step for each request mode; the unused mode reports straight away
   function automatic upc_type mode_entry(input mode_type m);
      upc_type u;
      case (m)
         MODE_WRITE: u = U_WR;
         MODE_EXEC:  u = U_EXEC;
         MODE_READ:  u = U_RD;
         default:    u = U_IDLE;
      endcase
      return u;
   endfunction

   // Entry step for each opcode; anything unknown halts
   function automatic upc_type opc_entry(input opc_type o);
      upc_type u;
      case (o)
         OP_LDA:  u = U_LDA;
         OP_STA:  u = U_STA;
         OP_LDB:  u = U_LDB;
         OP_STB:  u = U_STB;
         OP_ADD:  u = U_ADD;
         OP_SUB:  u = U_SUB;
         OP_JMP:  u = U_JMP;
         OP_JZ:   u = U_JZ;
         OP_HLT:  u = U_HLT;
         default: u = U_BAD;
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/acs_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface acs_req_if;
   import acs_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface acs_rsp_if;
   import acs_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/acs_useq.sv =====
// Microcode sequencer: step counter, control ROM, dispatch and branches.
`include "assert_macros.svh"

module acs_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  acs_pkg::mode_type   req_mode,
   output logic                req_ready,
   input  acs_pkg::flags_type  flags,
   output acs_pkg::dp_ctrl_type ctrl,
   output acs_pkg::evt_type    evt
);
   import acs_pkg::*;

   upc_type   upc_ff;
   upc_type   upc_in;
   upc_type   upc_seq;
   logic      pend_ff;
   logic      pend_in;
   logic      idle;
   uword_type uw;

   // Current control word
   assign uw      = ucode_rom(upc_ff);
   assign ctrl    = uw.dp;
   assign upc_seq = upc_type'(upc_ff + 1'b1);

   // Idle step: hand over the finished result and take the next beat together
   assign idle      = (uw.seq == SEQ_DISP_MODE);
   assign req_ready = idle && (!pend_ff || flags.out_free);
   assign evt.accept = req_valid && req_ready;
   assign evt.emit   = idle && pend_ff && flags.out_free;

   // Next step
   always_comb begin
      case (uw.seq)
         SEQ_NEXT:      upc_in = upc_seq;
         SEQ_JUMP:      upc_in = uw.target;
         SEQ_CLR_LOOP:  upc_in = flags.clr_last ? upc_seq : upc_ff;
         SEQ_DISP_MODE: upc_in = evt.accept ? mode_entry(req_mode) : upc_ff;
         SEQ_BR_HALT:   upc_in = flags.running ? upc_seq : uw.target;
         SEQ_DISP_OPC:  upc_in = opc_entry(flags.opcode);
         default:       upc_in = U_IDLE;
      endcase
   end

   // A result is pending from acceptance until it is handed over
   always_comb begin
      if (evt.accept) begin
         pend_in = 1'b1;
      end else if (evt.emit) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= U_CLEAR;
         pend_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         pend_ff <= pend_in;
      end
   end

   `ASSERT_NEXT(a_accept_sets_pending, clock, reset, evt.accept, pend_ff, "accepted beat left no pending result")
   `ASSERT_IMPLIES(a_no_accept_in_clear, clock, reset, upc_ff == U_CLEAR, !req_ready, "request taken during memory clear")
   `ASSERT_NEXT(a_work_leaves_idle, clock, reset, evt.accept && (req_mode != MODE_NONE), upc_ff != U_IDLE, "accepted work did not start")

endmodule

// ===== hw/rtl/acs_dpath.sv =====
// Datapath: word memory, processor registers and the result register.
`include "assert_macros.svh"

module acs_dpath #(
   parameter int unsigned MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  acs_pkg::req_type     req_data,
   input  acs_pkg::dp_ctrl_type ctrl,
   input  acs_pkg::evt_type     evt,
   input  logic                 rsp_ready,
   output acs_pkg::flags_type   flags,
   output logic                 rsp_valid,
   output acs_pkg::rsp_type     rsp_data
);
   import acs_pkg::*;

   // Word address width; MEM_WORDS is a power of two so wrapping keeps low bits
   localparam int unsigned AW = $clog2(MEM_WORDS);

   logic [DATA_BITS-1:0] word_store_ff [MEM_WORDS];

   logic [AW-1:0]        addr_ff, addr_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic [DATA_BITS-1:0] ir_ff, ir_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;
   logic [DATA_BITS-1:0] b_ff, b_in;
   logic [AW-1:0]        pc_ff, pc_in;
   logic                 zero_ff, zero_in;
   logic                 run_ff, run_in;
   logic [AW-1:0]        clr_ff, clr_in;
   status_type           st_ff, st_in;
   opc_type              opc_ff, opc_in;
   logic [DATA_BITS-1:0] rd_ff, rd_in;
   logic                 wr_ff, wr_in;
   logic [DATA_BITS-1:0] mem_q_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [AW-1:0]        opnd;
   logic [AW-1:0]        pc_inc;
   logic [AW-1:0]        mem_addr;
   logic [DATA_BITS-1:0] mem_wdata;
   logic [DATA_BITS-1:0] alu;
   logic                 alu_op;

   assign opnd   = ir_ff[AW-1:0];
   assign pc_inc = AW'(pc_ff + 1'b1);
   assign alu_op = (ctrl.acc_op == ACC_ADD) || (ctrl.acc_op == ACC_SUB);

   // Memory address and write data selection
   always_comb begin
      case (ctrl.addr_sel)
         ADDR_REQ:  mem_addr = addr_ff;
         ADDR_PC:   mem_addr = pc_ff;
         ADDR_OPND: mem_addr = opnd;
         ADDR_CLR:  mem_addr = clr_ff;
         default:   mem_addr = addr_ff;
      endcase
      case (ctrl.wd_sel)
         WD_REQ:  mem_wdata = data_ff;
         WD_ACC:  mem_wdata = acc_ff;
         WD_B:    mem_wdata = b_ff;
         WD_ZERO: mem_wdata = '0;
         default: mem_wdata = '0;
      endcase
   end

   // Single port word memory with registered read data
   always_ff @(posedge clock) begin
      if (ctrl.mem_op == MEM_WR) begin
         word_store_ff[mem_addr] <= mem_wdata;
      end
      if (ctrl.mem_op == MEM_RD) begin
         mem_q_ff <= word_store_ff[mem_addr];
      end
   end

   // Shared adder for add and subtract
   assign alu = (ctrl.acc_op == ACC_SUB) ? (acc_ff - b_ff) : (acc_ff + b_ff);

   // Register next values
   always_comb begin
      addr_in = evt.accept ? req_data.address[AW-1:0] : addr_ff;
      data_in = evt.accept ? req_data.data : data_ff;
      ir_in   = ctrl.ir_load ? mem_q_ff : ir_ff;
      b_in    = ctrl.b_load ? mem_q_ff : b_ff;
      run_in  = ctrl.halt ? 1'b0 : run_ff;
      zero_in = alu_op ? (alu == '0) : zero_ff;
      clr_in  = ctrl.clr_step ? AW'(clr_ff + 1'b1) : clr_ff;

      case (ctrl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = mem_q_ff;
         ACC_ADD:  acc_in = alu;
         ACC_SUB:  acc_in = alu;
         default:  acc_in = acc_ff;
      endcase

      case (ctrl.pc_op)
         PC_HOLD: pc_in = pc_ff;
         PC_INC:  pc_in = pc_inc;
         PC_LOAD: pc_in = opnd;
         PC_JZ:   pc_in = zero_ff ? opnd : pc_inc;
         default: pc_in = pc_ff;
      endcase

      // Per-item report fields start from their defaults on acceptance
      if (evt.accept) begin
         st_in  = ST_ACCESS;
         opc_in = '0;
         rd_in  = '0;
         wr_in  = 1'b0;
      end else begin
         st_in  = ctrl.st_set ? ctrl.st_val : st_ff;
         opc_in = ctrl.ir_load ? mem_q_ff[OPC_SHIFT +: OPC_BITS] : opc_ff;
         rd_in  = ctrl.rd_load ? mem_q_ff : rd_ff;
         wr_in  = ctrl.written | wr_ff;
      end
   end

   // Result beat built from the state after the item
   always_comb begin
      rsp_in.status      = st_ff;
      rsp_in.opcode      = opc_ff;
      rsp_in.accumulator = acc_ff;
      rsp_in.b_value     = b_ff;
      rsp_in.pc          = ADDR_BITS'(pc_ff);
      rsp_in.zero        = zero_ff;
      rsp_in.read_data   = rd_ff;
      rsp_in.mem_written = wr_ff;
   end

   always_comb begin
      if (evt.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         b_ff         <= '0;
         pc_ff        <= '0;
         zero_ff      <= 1'b0;
         run_ff       <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         b_ff         <= b_in;
         pc_ff        <= pc_in;
         zero_ff      <= zero_in;
         run_ff       <= run_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      data_ff <= data_in;
      ir_ff   <= ir_in;
      st_ff   <= st_in;
      opc_ff  <= opc_in;
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      if (evt.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign flags.running  = run_ff;
   assign flags.clr_last = (clr_ff == AW'(MEM_WORDS - 1));
   assign flags.out_free = !rsp_valid_ff || rsp_ready;
   assign flags.opcode   = mem_q_ff[OPC_SHIFT +: OPC_BITS];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLIES(a_emit_slot_free, clock, reset, evt.emit, !rsp_valid_ff || rsp_ready, "result register overwritten")
   `ASSERT_NEXT(a_halt_sticky, clock, reset, !run_ff, !run_ff, "processor left halt without reset")
   `ASSERT_IMPLIES(a_halted_pc_frozen, clock, reset, !run_ff, ctrl.pc_op == PC_HOLD, "program counter moved while halted")

endmodule

// ===== hw/rtl/accumulator_cpu_step_top.sv =====
// Top level of the microcoded accumulator step block.
//
// Requests arrive on req_ch: mode 0 writes a memory word, mode 1 executes
// one instruction at the program counter, mode 2 reads a memory word,
// mode 3 does nothing. Every request beat gives exactly one result beat on
// rsp_ch with the processor registers as they stand after the item.
// A microcode step counter runs each item over a single port word memory
// with registered read data; one step per cycle, including the idle step
// that takes the beat. Then a write takes a write step, a read a read and
// a capture step, mode 3 none; execute reads the word at the pc, reports
// if halted, else decodes it and runs one store/add/subtract/jump/halt
// step or, for loads, an operand read and a load step. The result is loaded
// into the output register at the idle step after the item and appears in
// the next cycle. After reset the memory is cleared one word a cycle, all
// MEM_WORDS words (1024 by default), with req_ch.ready low; registers
// reset to zero and the processor is running. When the receiver stalls,
// the result waits in the output register; the next item is still taken
// and run, and waits at the idle step until the register is free.
module accumulator_cpu_step_top #(
   parameter int unsigned MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
   input logic       clock,
   input logic       reset,
   acs_req_if.sink   req_ch,
   acs_rsp_if.source rsp_ch
);
   import acs_pkg::*;

   flags_type   flags;
   dp_ctrl_type ctrl;
   evt_type     evt;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_data;

   acs_useq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.payload.mode),
      .req_ready (req_ready),
      .flags     (flags),
      .ctrl      (ctrl),
      .evt       (evt)
   );

   acs_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_ch.payload),
      .ctrl      (ctrl),
      .evt       (evt),
      .rsp_ready (rsp_ch.ready),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_data;

endmodule

// ===== test/accumulator_cpu_step_top_tb.sv =====
// Self-checking testbench for the accumulator step block: directed programs, random steps, halt.
`timescale 1ns / 1ps

module accumulator_cpu_step_top_tb;
   import acs_pkg::*;

   localparam int unsigned MEM_WORDS     = MEM_WORDS_DEF;
   localparam int unsigned MAX_WAIT      = 14;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned RANDOM_BEATS  = 1400;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned RESET_CYCLES  = 11;

   // Cleared memory decodes to this opcode
   localparam opc_type OP_BLANK = '0;

   logic clock;
   logic reset;

   acs_req_if req_ch ();
   acs_rsp_if rsp_ch ();

   accumulator_cpu_step_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted processor state
   logic [31:0] mem_words [MEM_WORDS];
   logic [31:0] cpu_acc;
   logic [31:0] cpu_b;
   logic [26:0] cpu_pc;
   logic        cpu_zero;
   logic        cpu_running;

   rsp_type     awaited_snapshots [$];
   int unsigned error_count   = 0;
   int unsigned counted_beats = 0;
   int unsigned quiet_cycles  = 0;
   bit          idling        = 1'b1;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("accumulator_cpu_step_top: mismatch");
            $finish;
         end
      end
   end

   function automatic int unsigned mem_index(input logic [26:0] a);
      return a % MEM_WORDS;
   endfunction

   // Program counter after a sequential step, wrapped to the memory
   function automatic logic [26:0] pc_next();
      return 27'((cpu_pc + 1) % MEM_WORDS);
   endfunction

   function automatic int unsigned draw_wait();
      return idling ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   // One step of the processor: updates the predicted state, returns the snapshot
   function automatic rsp_type step_cpu(input req_type r);
      rsp_type     snap;
      logic [31:0] instr;
      int unsigned opnd;
      opc_type     op;
      snap        = '0;
      snap.status = ST_ACCESS;
      case (r.mode)
         MODE_WRITE: mem_words[mem_index(r.address)] = r.data;
         MODE_READ:  snap.read_data = mem_words[mem_index(r.address)];
         MODE_EXEC: begin
            if (!cpu_running) begin
               snap.status = ST_HALTED;
            end else begin
               instr       = mem_words[mem_index(cpu_pc)];
               op          = instr[31:27];
               opnd        = mem_index(instr[26:0]);
               snap.opcode = op;
               snap.status = ST_EXEC;
               case (op)
                  OP_LDA: begin
                     cpu_acc = mem_words[opnd];
                     cpu_pc  = pc_next();
                  end
                  OP_STA: begin
                     mem_words[opnd]  = cpu_acc;
                     snap.mem_written = 1'b1;
                     cpu_pc           = pc_next();
                  end
                  OP_LDB: begin
                     cpu_b  = mem_words[opnd];
                     cpu_pc = pc_next();
                  end
                  OP_STB: begin
                     mem_words[opnd]  = cpu_b;
                     snap.mem_written = 1'b1;
                     cpu_pc           = pc_next();
                  end
                  OP_ADD: begin
                     cpu_acc  = cpu_acc + cpu_b;
                     cpu_zero = (cpu_acc == '0);
                     cpu_pc   = pc_next();
                  end
                  OP_SUB: begin
                     cpu_acc  = cpu_acc - cpu_b;
                     cpu_zero = (cpu_acc == '0);
                     cpu_pc   = pc_next();
                  end
                  OP_JMP: cpu_pc = 27'(opnd);
                  OP_JZ:  cpu_pc = cpu_zero ? 27'(opnd) : pc_next();
                  OP_HLT: begin
                     cpu_running = 1'b0;
                     snap.status = ST_HALT;
                  end
                  default: begin
                     cpu_running = 1'b0;
                     snap.status = ST_BAD_OP;
                  end
               endcase
            end
         end
         default: ;
      endcase
      snap.accumulator = cpu_acc;
      snap.b_value     = cpu_b;
      snap.pc          = cpu_pc;
      snap.zero        = cpu_zero;
      return snap;
   endfunction

   function automatic logic [31:0] make_instr(input opc_type op, input logic [26:0] opnd);
      return {op, opnd};
   endfunction

   // Operands mostly land in a small data pool, upper bits always random
   function automatic logic [26:0] rand_operand();
      logic [26:0] v;
      v = 27'($urandom);
      if ($urandom_range(0, 4) != 0) v = (v & ~27'(MEM_WORDS - 1)) | 27'($urandom_range(0, 31));
      return v;
   endfunction

   // Data words biased towards values that make the zero flag and wraps happen
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Send one request beat; predicts its result once accepted
   task automatic send_beat(input mode_type mode, input logic [26:0] address,
                            input logic [31:0] data);
      int unsigned gap;
      req_type     beat;
      gap          = draw_wait();
      beat.mode    = mode;
      beat.address = address;
      beat.data    = data;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= beat;
      do @(posedge clock); while (!req_ch.ready);
      awaited_snapshots.push_back(step_cpu(beat));
      if (mode != MODE_NONE) counted_beats++;
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_snapshots.size() != 0);
   endtask

   // Execute one step, planting a fresh legal instruction at the pc when needed and at random times
   task automatic run_instruction();
      logic [31:0] word;
      opc_type     op;
      logic [26:0] where;
      word = mem_words[mem_index(cpu_pc)];
      op   = word[31:27];
      if (op < OP_LDA || op > OP_JZ || $urandom_range(0, 1) == 0) begin
         where = (27'($urandom) & ~27'(MEM_WORDS - 1)) | cpu_pc;
         send_beat(MODE_WRITE, where,
                   make_instr(opc_type'($urandom_range(OP_LDA, OP_JZ)), rand_operand()));
      end
      send_beat(MODE_EXEC, 27'($urandom), $urandom);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   // Result side: random stalls, compare each beat with the oldest snapshot
   initial begin : result_checker
      int unsigned stall;
      rsp_type     want;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (awaited_snapshots.size() == 0) begin
            $error("result beat with no result outstanding");
            error_count++;
         end else begin
            want = awaited_snapshots.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_ch.payload.status));
            check_field("opcode", 32'(want.opcode), 32'(rsp_ch.payload.opcode));
            check_field("accumulator", want.accumulator, rsp_ch.payload.accumulator);
            check_field("b_value", want.b_value, rsp_ch.payload.b_value);
            check_field("pc", 32'(want.pc), 32'(rsp_ch.payload.pc));
            check_field("zero", 32'(want.zero), 32'(rsp_ch.payload.zero));
            check_field("read_data", want.read_data, rsp_ch.payload.read_data);
            check_field("mem_written", 32'(want.mem_written),
                        32'(rsp_ch.payload.mem_written));
         end
      end
   end

   // Cleared memory, top address wrap, the unused mode
   task automatic test_memory_access();
      idling = 1'b1;
      send_beat(MODE_READ, '0, $urandom);
      send_beat(MODE_WRITE, '1, '1);
      send_beat(MODE_READ, 27'(MEM_WORDS - 1), '0);
      send_beat(MODE_NONE, '1, '1);
   endtask

   // Small program touching every opcode but halt, carry wrap both ways and both jz outcomes
   task automatic test_instruction_set();
      idling = 1'b1;
      send_beat(MODE_WRITE, 27'd100, '1);
      send_beat(MODE_WRITE, 27'd101, 32'd1);
      send_beat(MODE_WRITE, 27'd0, make_instr(OP_LDA, 27'h7FFFC64));
      send_beat(MODE_WRITE, 27'd1, make_instr(OP_LDB, 27'd101));
      send_beat(MODE_WRITE, 27'd2, make_instr(OP_ADD, 27'($urandom)));
      send_beat(MODE_WRITE, 27'd3, make_instr(OP_JZ, 27'd6));
      send_beat(MODE_WRITE, 27'd6, make_instr(OP_SUB, 27'($urandom)));
      send_beat(MODE_WRITE, 27'd7, make_instr(OP_JZ, 27'd3));
      send_beat(MODE_WRITE, 27'd8, make_instr(OP_STA, 27'h4000066));
      send_beat(MODE_WRITE, 27'd9, make_instr(OP_STB, 27'h2AAA867));
      send_beat(MODE_WRITE, 27'd10, make_instr(OP_JMP, '1));
      send_beat(MODE_WRITE, 27'(MEM_WORDS - 1), make_instr(OP_LDA, 27'd102));
      // hold off until the whole program is in
      drain_results();
      // ten steps run the program and wrap the pc from the top back to zero
      repeat (10) send_beat(MODE_EXEC, '0, '0);
      send_beat(MODE_READ, 27'd103, '0);
   endtask

   // Mostly executed instructions, with data writes, reads and noise mixed in
   task automatic test_random_steps();
      int unsigned start;
      int unsigned pick;
      int unsigned rounds;
      start  = counted_beats;
      rounds = 0;
      while (counted_beats - start < RANDOM_BEATS) begin
         if (rounds % 64 == 0) idling = ($urandom_range(0, 3) != 0);
         rounds++;
         pick = $urandom_range(0, 99);
         if (pick < 65)      run_instruction();
         else if (pick < 80) send_beat(MODE_WRITE, rand_operand(), rand_word());
         else if (pick < 92) send_beat(MODE_READ, rand_operand(), $urandom);
         else if (pick < 97) send_beat(MODE_WRITE, 27'($urandom), $urandom);
         else                send_beat(MODE_NONE, 27'($urandom), $urandom);
      end
   endtask

   // Halt is sticky until reset, so one kind of halt per run, picked at random
   task automatic test_halting();
      opc_type     op;
      logic [26:0] where;
      idling = 1'b1;
      case ($urandom_range(0, 2))
         0:       op = OP_HLT;
         1:       op = opc_type'($urandom_range(OP_JZ + 1, OP_HLT - 1));
         default: op = OP_BLANK;
      endcase
      where = (27'($urandom) & ~27'(MEM_WORDS - 1)) | cpu_pc;
      send_beat(MODE_WRITE, where, make_instr(op, 27'($urandom)));
      send_beat(MODE_EXEC, '0, '0);
      send_beat(MODE_EXEC, 27'($urandom), $urandom);
      // memory stays reachable once halted
      send_beat(MODE_WRITE, rand_operand(), $urandom);
      send_beat(MODE_READ, where, '0);
      send_beat(MODE_NONE, 27'($urandom), $urandom);
      send_beat(MODE_EXEC, '0, '0);
   endtask

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = '0;
      cpu_acc     = '0;
      cpu_b       = '0;
      cpu_pc      = '0;
      cpu_zero    = 1'b0;
      cpu_running = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_memory_access();
      test_instruction_set();
      test_random_steps();
      test_halting();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("accumulator_cpu_step_top: match");
      end else begin
         $display("accumulator_cpu_step_top: mismatch");
      end
      $finish;
   end

endmodule
